FILE: design/bounded_undo_redo_stack_top_macros.svh
// -----------------------------------------------------------------------------
// bounded_undo_redo_stack_top_macros.svh
// Assertion shorthands for the undo/redo history block.
// -----------------------------------------------------------------------------
`ifndef BOUNDED_UNDO_REDO_STACK_TOP_MACROS_SVH
`define BOUNDED_UNDO_REDO_STACK_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BURS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BURS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/burs_pkg.sv
// -----------------------------------------------------------------------------
// burs_pkg
// Shared types and constants for the undo/redo history block.
// -----------------------------------------------------------------------------
package burs_pkg;

  localparam int unsigned DEPTH_DEF     = 256;
  localparam int unsigned CMD_WIDTH_DEF = 64;

  // fixed field widths of the stream beats
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned PAYLOAD_W   = 64;
  localparam int unsigned DEPTH_OUT_W = 9;
  localparam int unsigned OUT_DATA_W  = 88;  // 64 + 9 + 9, padded to bytes
  localparam int unsigned OUT_PAD_W   = OUT_DATA_W - PAYLOAD_W - 2 * DEPTH_OUT_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_UNDO  = 2'd1,
    KIND_REDO  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // per-stack command for one cycle
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctrl_t;

endpackage

FILE: design/burs_cell.sv
// -----------------------------------------------------------------------------
// burs_cell
// One stack entry: loads from the upper neighbor on push, the lower on pop.
// -----------------------------------------------------------------------------
module burs_cell #(
  parameter int unsigned CMD_WIDTH = burs_pkg::CMD_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 push_i,
  input  logic                 pop_i,
  input  logic [CMD_WIDTH-1:0] above_i,
  input  logic [CMD_WIDTH-1:0] below_i,
  output logic [CMD_WIDTH-1:0] data_o
);

  logic [CMD_WIDTH-1:0] data_q;
  logic [CMD_WIDTH-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (push_i) begin
      data_d = above_i;
    end else if (pop_i) begin
      data_d = below_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: design/burs_stack.sv
// -----------------------------------------------------------------------------
// burs_stack
// Shift stack built from a row of cells; top of stack is always cell 0.
// -----------------------------------------------------------------------------
module burs_stack #(
  parameter int unsigned DEPTH     = burs_pkg::DEPTH_DEF,
  parameter int unsigned CMD_WIDTH = burs_pkg::CMD_WIDTH_DEF,
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  burs_pkg::stk_ctrl_t  ctrl_i,
  input  logic [CMD_WIDTH-1:0] push_data_i,
  output logic [CMD_WIDTH-1:0] top_o,
  output logic [CNT_W-1:0]     count_o,
  output logic [CNT_W-1:0]     count_nxt_o
);

  logic [CMD_WIDTH-1:0] cell_data [DEPTH];
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     count_d;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CMD_WIDTH-1:0] above;
    logic [CMD_WIDTH-1:0] below;

    if (i == 0) begin : g_head
      assign above = push_data_i;
    end else begin : g_body
      assign above = cell_data[i-1];
    end

    // bottom cell has nothing below; what it keeps is past the fill level
    if (i == DEPTH - 1) begin : g_tail
      assign below = cell_data[i];
    end else begin : g_inner
      assign below = cell_data[i+1];
    end

    burs_cell #(
      .CMD_WIDTH (CMD_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .push_i  (ctrl_i.push),
      .pop_i   (ctrl_i.pop),
      .above_i (above),
      .below_i (below),
      .data_o  (cell_data[i])
    );
  end

  // full push drops the bottom entry, count saturates
  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.push) begin
      if (count_q != CNT_W'(DEPTH)) begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (ctrl_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign top_o       = cell_data[0];
  assign count_o     = count_q;
  assign count_nxt_o = count_d;

endmodule

FILE: design/bounded_undo_redo_stack_top.sv
// -----------------------------------------------------------------------------
// bounded_undo_redo_stack_top: two-stack undo/redo history of command words
// An input beat is latched into the op registers, then executed into the result register.
// The sequencer takes no new input beat until the latched one has executed.
// Reset: both depths go to 0; cell contents are left as they are.
// -----------------------------------------------------------------------------
`include "bounded_undo_redo_stack_top_macros.svh"

// Each stack is a row of cells that shifts as a whole: a push moves every
// entry one cell down, a pop moves every entry one cell up. The newest entry
// sits in cell 0, so undo and redo read their word without any addressing.
// When the undo stack is full a push shifts the oldest entry out of the
// bottom cell, which is exactly the drop-oldest behavior of a ring.
//
// Sequencer: ST_IDLE takes one input beat into the op registers; ST_EXEC
// waits until the result register is free (empty, or being taken this
// cycle), then shifts the stacks and loads the result. A new input beat is
// taken while the previous result still waits on the master side.
module bounded_undo_redo_stack_top #(
  parameter int unsigned DEPTH     = burs_pkg::DEPTH_DEF,
  parameter int unsigned CMD_WIDTH = burs_pkg::CMD_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [burs_pkg::PAYLOAD_W-1:0]     s_axis_tdata,  // [63:0] payload
  input  logic [burs_pkg::KIND_W-1:0]        s_axis_tuser,  // [1:0] kind
  // master side
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [63:0] cmd_out, [72:64] undo_depth, [81:73] redo_depth, [87:82] zero
  output logic [burs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tuser   // [0] ok
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  burs_pkg::state_e state_q;
  burs_pkg::state_e state_d;

  // latched op
  burs_pkg::kind_e      kind_q;
  logic [CMD_WIDTH-1:0] payload_q;

  // result register
  logic                                m_valid_q;
  logic                                m_valid_d;
  logic                                m_ok_q;
  logic [CMD_WIDTH-1:0]                m_cmd_q;
  logic [burs_pkg::DEPTH_OUT_W-1:0]    m_undo_q;
  logic [burs_pkg::DEPTH_OUT_W-1:0]    m_redo_q;

  logic in_beat;
  logic fire;

  // stack side
  burs_pkg::stk_ctrl_t  undo_ctrl;
  burs_pkg::stk_ctrl_t  redo_ctrl;
  logic [CMD_WIDTH-1:0] undo_push_data;
  logic [CMD_WIDTH-1:0] undo_top;
  logic [CMD_WIDTH-1:0] redo_head;
  logic [CNT_W-1:0]     undo_cnt;
  logic [CNT_W-1:0]     redo_cnt;
  logic [CNT_W-1:0]     undo_cnt_nxt;
  logic [CNT_W-1:0]     redo_cnt_nxt;
  logic                 undo_empty;
  logic                 redo_empty;
  logic                 res_ok;
  logic [CMD_WIDTH-1:0] res_cmd;
  logic [CNT_W:0]       cnt_sum;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      burs_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_d = burs_pkg::ST_EXEC;
        end
      end
      burs_pkg::ST_EXEC: begin
        if (fire) begin
          state_d = burs_pkg::ST_IDLE;
        end
      end
      default: state_d = burs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    fire          = 1'b0;
    case (state_q)
      burs_pkg::ST_IDLE: s_axis_tready = 1'b1;
      burs_pkg::ST_EXEC: fire = !m_valid_q || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        fire          = 1'b0;
      end
    endcase
  end

  assign in_beat = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= burs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      kind_q    <= burs_pkg::kind_e'(s_axis_tuser);
      payload_q <= s_axis_tdata[CMD_WIDTH-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stack commands
  // ---------------------------------------------------------------------------
  assign undo_empty = (undo_cnt == '0);
  assign redo_empty = (redo_cnt == '0);

  always_comb begin
    undo_ctrl      = '0;
    redo_ctrl      = '0;
    undo_push_data = payload_q;
    res_ok         = 1'b1;
    res_cmd        = '0;
    case (kind_q)
      burs_pkg::KIND_PUSH: begin
        // new command invalidates the redo history
        undo_ctrl.push  = fire;
        redo_ctrl.clear = fire;
      end
      burs_pkg::KIND_UNDO: begin
        res_ok         = !undo_empty;
        undo_ctrl.pop  = fire && !undo_empty;
        redo_ctrl.push = fire && !undo_empty;
        if (!undo_empty) begin
          res_cmd = undo_top;
        end
      end
      burs_pkg::KIND_REDO: begin
        res_ok         = !redo_empty;
        redo_ctrl.pop  = fire && !redo_empty;
        undo_ctrl.push = fire && !redo_empty;
        undo_push_data = redo_head;
        if (!redo_empty) begin
          res_cmd = redo_head;
        end
      end
      burs_pkg::KIND_CLEAR: begin
        undo_ctrl.clear = fire;
        redo_ctrl.clear = fire;
      end
      default: begin
        undo_ctrl = '0;
        redo_ctrl = '0;
      end
    endcase
  end

  burs_stack #(
    .DEPTH     (DEPTH),
    .CMD_WIDTH (CMD_WIDTH)
  ) u_undo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (undo_ctrl),
    .push_data_i (undo_push_data),
    .top_o       (undo_top),
    .count_o     (undo_cnt),
    .count_nxt_o (undo_cnt_nxt)
  );

  // undo + redo never exceeds DEPTH, so a push here never drops an entry
  burs_stack #(
    .DEPTH     (DEPTH),
    .CMD_WIDTH (CMD_WIDTH)
  ) u_redo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (redo_ctrl),
    .push_data_i (undo_top),
    .top_o       (redo_head),
    .count_o     (redo_cnt),
    .count_nxt_o (redo_cnt_nxt)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_comb begin
    m_valid_d = m_valid_q;
    if (fire) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  // depth fields keep the low 9 bits of the counts
  always_ff @(posedge clk_i) begin
    if (fire) begin
      m_ok_q   <= res_ok;
      m_cmd_q  <= res_cmd;
      m_undo_q <= burs_pkg::DEPTH_OUT_W'(undo_cnt_nxt);
      m_redo_q <= burs_pkg::DEPTH_OUT_W'(redo_cnt_nxt);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_ok_q;
  assign m_axis_tdata  = {{burs_pkg::OUT_PAD_W{1'b0}}, m_redo_q, m_undo_q,
                          burs_pkg::PAYLOAD_W'(m_cmd_q)};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  assign cnt_sum = (CNT_W + 1)'(undo_cnt) + (CNT_W + 1)'(redo_cnt);

  `BURS_ASSERT_NOW(a_cnt_sum, clk_i, rst_ni, 1'b1, cnt_sum <= (CNT_W + 1)'(DEPTH),
    "undo plus redo depth exceeds DEPTH")
  `BURS_ASSERT_NXT(a_clear, clk_i, rst_ni, fire && kind_q == burs_pkg::KIND_CLEAR,
    undo_cnt == '0 && redo_cnt == '0, "clear left entries on a stack")
  `BURS_ASSERT_NXT(a_push, clk_i, rst_ni, fire && kind_q == burs_pkg::KIND_PUSH,
    redo_cnt == '0 && undo_cnt != '0, "push did not empty redo or fill undo")
  `BURS_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, m_valid_q && !m_ok_q, m_cmd_q == '0,
    "failed pop returned a nonzero word")

endmodule

FILE: verif/bounded_undo_redo_stack_top_tb.sv
// -----------------------------------------------------------------------------
// bounded_undo_redo_stack_top_tb: self-checking bench for the undo/redo history
// Drives push, undo, redo and clear beats into the slave stream, keeps its own
// two-stack history model and checks every result beat (ok flag, popped word,
// both depths, pad bits) in order. Random gaps and stalls on both streams, one
// long master hold-off so the block backs up its input.
// -----------------------------------------------------------------------------
module bounded_undo_redo_stack_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HIST_DEPTH   = burs_pkg::DEPTH_DEF;
  localparam int unsigned WORD_W       = burs_pkg::CMD_WIDTH_DEF;
  localparam logic [63:0] WORD_MASK    = {64{1'b1}} >> (64 - WORD_W);
  localparam int unsigned HOLD_CYCLES  = 300;
  // ~1000 beats with their gaps and stalls, plus the hold-off, with margin
  localparam int unsigned CYCLE_LIMIT  = 500000;

  // expected content of one result beat
  typedef struct packed {
    logic       ok;
    logic [63:0] word;
    logic [8:0] undo_n;
    logic [8:0] redo_n;
  } hist_result_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [burs_pkg::PAYLOAD_W-1:0]      s_axis_tdata  = '0;
  logic [burs_pkg::KIND_W-1:0]         s_axis_tuser  = burs_pkg::KIND_PUSH;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [burs_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
  logic                                m_axis_tuser;

  bounded_undo_redo_stack_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [63:0] payload
    .s_axis_tuser  (s_axis_tuser),   // [1:0] kind
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [63:0] cmd_out, [72:64] undo, [81:73] redo
    .m_axis_tuser  (m_axis_tuser)    // [0] ok
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // History model. The undo stack is a ring starting at ring_base; redo is a
  // plain LIFO. Both hold words masked to the command width.
  // ---------------------------------------------------------------------------
  logic [63:0]  undo_ring [HIST_DEPTH];
  logic [63:0]  redo_lifo [HIST_DEPTH];
  int unsigned  ring_base;
  int unsigned  undo_fill;
  int unsigned  redo_fill;

  hist_result_t expected_beats [$];
  int unsigned  error_cnt;
  int unsigned  cycle_cnt;

  // stimulus knobs shared with the master-side process
  bit           quiet;         // no gaps, no stalls
  int unsigned  hold_asks;     // bumped by a test to ask for a long hold-off
  int unsigned  hold_seen;
  int unsigned  hold_left;
  int unsigned  stretch_left;
  bit           ready_phase;

  // undo-side append: a full ring drops its oldest entry
  function automatic void undo_append(logic [63:0] w);
    if (undo_fill >= HIST_DEPTH) begin
      undo_ring[ring_base] = w;
      ring_base = (ring_base + 1) % HIST_DEPTH;
    end else begin
      undo_ring[(ring_base + undo_fill) % HIST_DEPTH] = w;
      undo_fill++;
    end
  endfunction

  function automatic hist_result_t history_apply(burs_pkg::kind_e op,
                                                 logic [63:0] payload);
    hist_result_t r;
    r.ok   = 1'b1;
    r.word = '0;
    case (op)
      burs_pkg::KIND_PUSH: begin
        redo_fill = 0;
        undo_append(payload & WORD_MASK);
      end
      burs_pkg::KIND_UNDO: begin
        if (undo_fill == 0) begin
          r.ok = 1'b0;
        end else begin
          undo_fill--;
          r.word = undo_ring[(ring_base + undo_fill) % HIST_DEPTH];
          if (redo_fill < HIST_DEPTH) begin
            redo_lifo[redo_fill] = r.word;
            redo_fill++;
          end
        end
      end
      burs_pkg::KIND_REDO: begin
        if (redo_fill == 0) begin
          r.ok = 1'b0;
        end else begin
          redo_fill--;
          r.word = redo_lifo[redo_fill];
          undo_append(r.word);
        end
      end
      default: begin
        ring_base = 0;
        undo_fill = 0;
        redo_fill = 0;
      end
    endcase
    r.undo_n = undo_fill[8:0];
    r.redo_n = redo_fill[8:0];
    return r;
  endfunction

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random command word, with the all-zero and all-one words mixed in
  function automatic logic [63:0] random_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 6) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // ---------------------------------------------------------------------------
  // Slave side: one beat per call. Entered and left at a falling edge; tvalid
  // stays high on return so a back-to-back beat needs no second assignment.
  // ---------------------------------------------------------------------------
  task automatic send_beat(burs_pkg::kind_e op, logic [63:0] payload);
    int unsigned gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= payload;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    expected_beats.push_back(history_apply(op, payload));
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Master side: random ready stretches, or a counted hold-off on request.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        ready_phase  = ($urandom_range(0, 99) < 60);
        stretch_left = ready_phase ? $urandom_range(1, 30) : idle_len() + 1;
      end
      stretch_left--;
      m_axis_tready <= ready_phase;
    end
  end

  task automatic report_mismatch(string field, logic [63:0] exp_v, logic [63:0] got_v);
    error_cnt++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
  endtask

  // result beats against the oldest expectation
  always @(posedge clk_i) begin
    hist_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        error_cnt++;
        $display("%0t: result beat with nothing expected, tdata 0x%0h ok %0b",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        exp_r = expected_beats.pop_front();
        if (m_axis_tuser !== exp_r.ok)
          report_mismatch("ok", exp_r.ok, m_axis_tuser);
        if (m_axis_tdata[63:0] !== exp_r.word)
          report_mismatch("cmd_out", exp_r.word, m_axis_tdata[63:0]);
        if (m_axis_tdata[72:64] !== exp_r.undo_n)
          report_mismatch("undo_depth", exp_r.undo_n, m_axis_tdata[72:64]);
        if (m_axis_tdata[81:73] !== exp_r.redo_n)
          report_mismatch("redo_depth", exp_r.redo_n, m_axis_tdata[81:73]);
        if (m_axis_tdata[burs_pkg::OUT_DATA_W-1:82] !== '0)
          report_mismatch("pad", '0, m_axis_tdata[burs_pkg::OUT_DATA_W-1:82]);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // pops and clear on a freshly reset block
  task automatic test_empty_after_reset();
    send_beat(burs_pkg::KIND_UNDO, '1);
    send_beat(burs_pkg::KIND_REDO, 64'h0123_4567_89ab_cdef);
    send_beat(burs_pkg::KIND_CLEAR, '0);
  endtask

  // each operation, extreme words, redo kept across redo, push wiping redo
  task automatic test_basic_ops();
    send_beat(burs_pkg::KIND_PUSH, '0);
    send_beat(burs_pkg::KIND_PUSH, '1);
    send_beat(burs_pkg::KIND_PUSH, 64'h5555_5555_5555_5555);
    send_beat(burs_pkg::KIND_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
    send_beat(burs_pkg::KIND_UNDO, '0);
    send_beat(burs_pkg::KIND_UNDO, '1);
    send_beat(burs_pkg::KIND_REDO, '0);
    send_beat(burs_pkg::KIND_REDO, '0);
    send_beat(burs_pkg::KIND_REDO, '0);              // redo now empty
    send_beat(burs_pkg::KIND_UNDO, '0);
    send_beat(burs_pkg::KIND_UNDO, '0);
    send_beat(burs_pkg::KIND_UNDO, '0);
    send_beat(burs_pkg::KIND_PUSH, 64'h8000_0000_0000_0001);   // drops redo history
    send_beat(burs_pkg::KIND_REDO, '0);
    send_beat(burs_pkg::KIND_CLEAR, '1);
    send_beat(burs_pkg::KIND_UNDO, '0);
    send_beat(burs_pkg::KIND_REDO, '0);
    send_beat(burs_pkg::KIND_PUSH, 64'hfeed_face_cafe_beef);
  endtask

  // overfill undo so the ring wraps and drops its oldest, then unwind all
  // of it onto redo and bring part back
  task automatic test_full_history();
    send_beat(burs_pkg::KIND_CLEAR, '0);
    repeat (HIST_DEPTH + 3) send_beat(burs_pkg::KIND_PUSH, random_word());
    repeat (HIST_DEPTH + 1) send_beat(burs_pkg::KIND_UNDO, random_word());
    repeat (5) send_beat(burs_pkg::KIND_REDO, random_word());
    send_beat(burs_pkg::KIND_UNDO, '0);
  endtask

  // master holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    hold_asks++;
    repeat (24) send_beat(burs_pkg::kind_e'($urandom_range(0, 2)), random_word());
  endtask

  // weighted random traffic in segments: push-heavy, unwind-heavy, mixed
  task automatic test_random_traffic();
    int unsigned     seg;
    int unsigned     n;
    int unsigned     roll;
    int unsigned     w_push;
    int unsigned     w_undo;
    int unsigned     w_redo;
    burs_pkg::kind_e op;
    for (seg = 0; seg < 6; seg++) begin
      quiet = (seg == 2);
      case (seg % 3)
        0:       begin w_push = 70; w_undo = 15; w_redo = 12; end
        1:       begin w_push = 25; w_undo = 40; w_redo = 33; end
        default: begin w_push = 40; w_undo = 30; w_redo = 27; end
      endcase
      for (n = 0; n < 75; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < w_push)                        op = burs_pkg::KIND_PUSH;
        else if (roll < w_push + w_undo)          op = burs_pkg::KIND_UNDO;
        else if (roll < w_push + w_undo + w_redo) op = burs_pkg::KIND_REDO;
        else                                      op = burs_pkg::KIND_CLEAR;
        send_beat(op, random_word());
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni    = 1'b0;
    ring_base = 0;
    undo_fill = 0;
    redo_fill = 0;
    error_cnt = 0;
    cycle_cnt = 0;
    quiet     = 1'b0;
    hold_asks = 0;
    hold_seen = 0;
    hold_left = 0;
    stretch_left = 0;
    ready_phase  = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_after_reset();
    test_basic_ops();
    test_full_history();
    test_backpressure();
    test_random_traffic();

    // drain: stop offering, wait for the last results, then keep running
    // so that a stray extra beat would still be caught
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
